/* rtl/lst_pkg.sv */
// Shared constants and codes for the label-steered target selector.
package lst_pkg;

  localparam int MAX_TARGETS = 16;
  localparam int NUM_LABELS  = 6;

  localparam int TGT_W   = 4;
  localparam int CNT_W   = 5;
  localparam int LABEL_W = 3;
  localparam int MASK_W  = 16;
  localparam int LFSR_W  = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // Request kinds
  localparam logic [1:0] FUNC_POLICY = 2'd0;
  localparam logic [1:0] FUNC_LABEL  = 2'd1;
  localparam logic [1:0] FUNC_TICKET = 2'd2;

  // Result error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_NO_TARGET = 2'd1;
  localparam logic [1:0] ERR_TICKET    = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_COUNT  = 3'd0;
  localparam logic [2:0] CFG_POLICY = 3'd1;
  localparam logic [2:0] CFG_MASK0  = 3'd2;

endpackage

/* rtl/lst_mod_step.sv */
// Radix-16 remainder step: folds one nibble into a running remainder mod count.
module lst_mod_step import lst_pkg::*; (
  input  logic [TGT_W-1:0] rem_in,
  input  logic [3:0]       nibble,
  input  logic [CNT_W-1:0] count,
  output logic [TGT_W-1:0] rem_out
);

  // Shift in one bit per slice; remainder stays below count so one subtract suffices
  always_comb begin
    logic [CNT_W-1:0] r;
    r = {1'b0, rem_in};
    for (int b = 3; b >= 0; b--) begin
      r = {r[CNT_W-2:0], nibble[b]};
      if (r >= count) begin
        r = r - count;
      end
    end
    rem_out = r[TGT_W-1:0];
  end

endmodule

/* rtl/label_steered_target_selector.sv */
// Top level: picks a target per request by label rotation, ticket or policy.
// Path, accept to out_valid: ticket, round-robin, single-target and error requests go
// straight to the done state; a random pick first runs four nibble steps of the shared remainder
// unit; a label request first searches up to count target slots, one per cycle.
// A new request is taken only after the result registers; out_stall delays that.
// Sync active-low rst_n: count 1, round robin, empty masks, zero pointers, LFSR 0xACE1.
module label_steered_target_selector import lst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [LABEL_W-1:0] in_label_id,
  input  logic [TGT_W-1:0]   in_ticket,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TGT_W-1:0]   out_target,
  output logic [1:0]         out_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [MASK_W-1:0]  cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   tc_r;
  logic               pol_r;
  logic [MASK_W-1:0]  mask_r [NUM_LABELS];
  logic [TGT_W-1:0]   lss_r  [NUM_LABELS];
  logic [TGT_W-1:0]   rr_r;
  logic [LFSR_W-1:0]  lfsr_r;

  logic [MASK_W-1:0]  live_r;
  logic [LABEL_W-1:0] label_r;
  logic [TGT_W-1:0]   idx_r;
  logic [TGT_W-1:0]   rem_r;
  logic [1:0]         cnt_r;
  logic [TGT_W-1:0]   res_tgt_r;
  logic [1:0]         res_err_r;

  logic               out_valid_r;
  logic [TGT_W-1:0]   out_tgt_r;
  logic [1:0]         out_err_r;

  logic [CNT_W-1:0]   n_live;
  logic [MASK_W:0]    low_bits;
  logic               label_ok;
  logic [LABEL_W-1:0] lbl_idx;
  logic [MASK_W-1:0]  live_in;
  logic [TGT_W-1:0]   start;
  logic [TGT_W-1:0]   rr_cur;
  logic [CNT_W-1:0]   rr_inc;
  logic [TGT_W-1:0]   rr_adv;
  logic [CNT_W-1:0]   idx_inc;
  logic [TGT_W-1:0]   idx_adv;
  logic [LFSR_W-1:0]  lfsr_nxt;
  logic [3:0]         nibble;
  logic [TGT_W-1:0]   unit_rem;
  logic               accept;
  logic               out_free;

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_target = out_tgt_r;
  assign out_error  = out_err_r;

  // Clamp the configured count into 1..MAX_TARGETS
  always_comb begin
    if (tc_r == '0) begin
      n_live = CNT_W'(1);
    end else if (tc_r > CNT_W'(MAX_TARGETS)) begin
      n_live = CNT_W'(MAX_TARGETS);
    end else begin
      n_live = tc_r;
    end
  end

  // Label lookup: live mask and wrapped search start
  assign low_bits = ({{MASK_W{1'b0}}, 1'b1} << n_live) - {{MASK_W{1'b0}}, 1'b1};
  assign label_ok = (in_label_id < LABEL_W'(NUM_LABELS));
  assign lbl_idx  = label_ok ? in_label_id : '0;
  assign live_in  = mask_r[lbl_idx] & low_bits[MASK_W-1:0];
  assign start    = ({1'b0, lss_r[lbl_idx]} >= n_live) ? '0 : lss_r[lbl_idx];

  // Round-robin pointer and search index advance with wrap
  assign rr_cur  = ({1'b0, rr_r} >= n_live) ? '0 : rr_r;
  assign rr_inc  = {1'b0, rr_cur} + CNT_W'(1);
  assign rr_adv  = (rr_inc >= n_live) ? '0 : rr_inc[TGT_W-1:0];
  assign idx_inc = {1'b0, idx_r} + CNT_W'(1);
  assign idx_adv = (idx_inc >= n_live) ? '0 : idx_inc[TGT_W-1:0];

  // Galois LFSR step
  assign lfsr_nxt = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);

  // Feed the remainder unit from the most significant nibble down
  assign nibble = lfsr_r[{~cnt_r, 2'b00} +: 4];

  lst_mod_step u_mod (
    .rem_in  (rem_r),
    .nibble  (nibble),
    .count   (n_live),
    .rem_out (unit_rem)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_LABEL) begin
            state_nxt = (label_ok && live_in != '0) ? S_SRCH : S_DONE;
          end else if (in_func == FUNC_TICKET || n_live == CNT_W'(1) || !pol_r) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (cnt_r == 2'd3) begin
          state_nxt = S_DONE;
        end
      end
      S_SRCH: begin
        if (live_r[idx_r]) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration and pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tc_r        <= CNT_W'(1);
      pol_r       <= 1'b0;
      rr_r        <= '0;
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LABELS; i++) begin
        mask_r[i] <= '0;
        lss_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Take configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_COUNT:  tc_r  <= cfg_data[CNT_W-1:0];
          CFG_POLICY: pol_r <= cfg_data[0];
          default:    mask_r[cfg_index - CFG_MASK0] <= cfg_data;
        endcase
      end

      // Advance pointers that the request consumes
      if (accept && in_func != FUNC_LABEL && in_func != FUNC_TICKET &&
          n_live != CNT_W'(1)) begin
        if (pol_r) begin
          lfsr_r <= lfsr_nxt;
        end else begin
          rr_r <= rr_adv;
        end
      end
      if (state_r == S_SRCH && live_r[idx_r]) begin
        lss_r[label_r] <= idx_adv;
      end

      // Load a new result when free, else drop the one taken
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      live_r  <= live_in;
      label_r <= lbl_idx;
      idx_r   <= start;
      rem_r   <= '0;
      cnt_r   <= '0;
      if (in_func == FUNC_LABEL) begin
        res_tgt_r <= '0;
        res_err_r <= (!label_ok || live_in == '0) ? ERR_NO_TARGET : ERR_OK;
      end else if (in_func == FUNC_TICKET) begin
        if ({1'b0, in_ticket} < n_live) begin
          res_tgt_r <= in_ticket;
          res_err_r <= ERR_OK;
        end else begin
          res_tgt_r <= '0;
          res_err_r <= ERR_TICKET;
        end
      end else begin
        res_tgt_r <= (n_live != CNT_W'(1) && !pol_r) ? rr_cur : '0;
        res_err_r <= ERR_OK;
      end
    end

    // Remainder steps for a random pick
    if (state_r == S_MOD) begin
      rem_r <= unit_rem;
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        res_tgt_r <= unit_rem;
      end
    end

    // Search one slot per cycle
    if (state_r == S_SRCH) begin
      if (live_r[idx_r]) begin
        res_tgt_r <= idx_r;
      end else begin
        idx_r <= idx_adv;
      end
    end

    // Hold result payload while stalled
    if (state_r == S_DONE && out_free) begin
      out_tgt_r <= res_tgt_r;
      out_err_r <= res_err_r;
    end
  end

endmodule

/* rtl/lst_checker.sv */
// Port-level checks for the label-steered target selector, bound to the top.
module lst_checker import lst_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [TGT_W-1:0]   out_target,
  input logic [1:0]         out_error
);

  // An error result always names target 0
  a_err_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error != ERR_OK |-> out_target == '0)
    else $error("error result with nonzero target");

  // Only defined error codes appear
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error == ERR_OK || out_error == ERR_NO_TARGET ||
                   out_error == ERR_TICKET))
    else $error("undefined error code");

  // A request in flight blocks the next one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_target) && $stable(out_error))
    else $error("stalled result changed");

endmodule

bind label_steered_target_selector lst_checker u_lst_checker (.*);
